FILE: design/cvt_pkg.sv
package cvt_pkg;

  // fixed formats
  localparam int TRIG_FRAC   = 14;
  localparam int TRIG_WIDTH  = 16;
  localparam int ROUND_HALF  = 1 << (TRIG_FRAC - 1);
  localparam int FOCAL_BITS  = 10;
  localparam int ANGLE_REG_BITS = 10;
  localparam int FRAC_BITS   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [FOCAL_BITS-1:0] FOCAL_RESET = 10'd160;

  // sine evaluation constants (Q31)
  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] ONE_Q31     = 64'd2147483648;
  localparam logic [63:0] DIV_TAB [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_YAW,
    REG_PITCH,
    REG_FOCAL
  } cfg_reg_t;

  // per-word sign and zero flags carried down the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_d;
    logic zero;
    logic nz_x;
    logic nz_y;
  } cvt_flags_t;

  // quarter-wave sine entry p, Q1.14, qb = log2 of the quarter length
  function automatic logic [TRIG_FRAC:0] quarter_sine(input int unsigned p,
                                                       input int unsigned qb);
    logic [63:0] t;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] term;
    t  = (64'(p) * HALF_PI_Q31 + (64'd1 << (qb - 1))) >> qb;
    x2 = (t * t) >> 31;
    r  = ONE_Q31;
    for (int k = 7; k >= 0; k--) begin
      term = ((x2 * r) >> 31) / DIV_TAB[k];
      r    = (term >= ONE_Q31) ? 64'd0 : ONE_Q31 - term;
    end
    s = (t * r) >> 31;
    s = (s + (64'd1 << 16)) >> 17;
    if (s > 64'd16384) s = 64'd16384;
    return s[TRIG_FRAC:0];
  endfunction

endpackage

FILE: design/cvt_front.sv
module cvt_front #(
  parameter int CW = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CW-1:0]    vertex_x,
  input  logic signed [CW-1:0]    vertex_y,
  input  logic signed [CW-1:0]    vertex_z,
  input  logic signed [CW-1:0]    cam_x,
  input  logic signed [CW-1:0]    cam_y,
  input  logic signed [CW-1:0]    cam_z,
  output logic                    push,
  input  logic                    room,
  output logic [3*(CW+1)-1:0]     push_data
);
  import cvt_pkg::*;

  localparam int DW = CW + 1;

  logic                 f_vld;
  logic signed [DW-1:0] dx, dy, dz;

  assign push      = f_vld && room;
  assign in_ready  = !f_vld || room;
  assign push_data = {dx, dy, dz};

  // translate by the camera and hold until the queue takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dx <= DW'(vertex_x) - DW'(cam_x);
      dy <= DW'(vertex_y) - DW'(cam_y);
      dz <= DW'(vertex_z) - DW'(cam_z);
    end
  end

endmodule

FILE: design/cvt_queue.sv
module cvt_queue #(
  parameter int W = 75
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         room,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);
  import cvt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign room      = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && room;
  assign do_pop    = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

FILE: design/cvt_back.sv
module cvt_back #(
  parameter int CW = 24,
  parameter int SCREEN_LINES = 160
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  logic [3*(CW+1)-1:0]           q_data,
  output logic                          pop,
  input  logic signed [cvt_pkg::TRIG_WIDTH-1:0] cos_yaw,
  input  logic signed [cvt_pkg::TRIG_WIDTH-1:0] sin_yaw,
  input  logic signed [cvt_pkg::TRIG_WIDTH-1:0] cos_pitch,
  input  logic signed [cvt_pkg::TRIG_WIDTH-1:0] sin_pitch,
  input  logic signed [CW-1:0]          cam_x,
  input  logic signed [CW-1:0]          cam_y,
  input  logic signed [CW-1:0]          cam_z,
  input  logic [cvt_pkg::FOCAL_BITS-1:0] focal,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [CW-1:0]          screen_x,
  output logic signed [CW-1:0]          screen_y,
  output logic signed [CW-1:0]          view_z,
  output logic                          depth_zero
);
  import cvt_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = DW + TRIG_WIDTH;
  localparam int RW = CW + 3;
  localparam int SW = RW + TRIG_WIDTH;
  localparam int SX = SW + 1;
  localparam int MW = RW;
  localparam int NW = MW + FOCAL_BITS + FRAC_BITS;
  localparam int EW = NW + 3;
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
  localparam logic signed [EW-1:0] SCREEN_Q = EW'(SCREEN_LINES * 256);

  function automatic logic signed [RW-1:0] round14(input logic signed [SX-1:0] v);
    logic [SX-1:0] mag;
    logic [SX-1:0] r;
    mag = v[SX-1] ? SX'(-v) : SX'(v);
    r   = (mag + SX'(ROUND_HALF)) >> TRIG_FRAC;
    return v[SX-1] ? -signed'(RW'(r)) : signed'(RW'(r));
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] v);
    if (v > SAT_HI) return CW'(SAT_HI);
    if (v < SAT_LO) return CW'(SAT_LO);
    return CW'(v);
  endfunction

  logic en;
  logic signed [DW-1:0] dx, dy, dz;

  // stage registers
  logic                 v1, v2, v3, v4;
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic signed [DW-1:0] dy1, dy2;
  logic signed [RW-1:0] rx2, zy2, rx3, rx4, ry4, dp4;
  logic signed [SW-1:0] q1, q2, q3, q4;

  // divider stages, index 0 loaded from the rotation result
  logic             dv    [NW+1];
  cvt_flags_t       dflg  [NW+1];
  logic [CW-1:0]    dvz   [NW+1];
  logic [MW-1:0]    dm    [NW+1];
  logic [MW-1:0]    rem_x [NW+1];
  logic [MW-1:0]    rem_y [NW+1];
  logic [NW-1:0]    num_x [NW+1];
  logic [NW-1:0]    num_y [NW+1];
  logic [NW-1:0]    quo_x [NW+1];
  logic [NW-1:0]    quo_y [NW+1];

  logic [MW-1:0]    ax4, ay4, ad4;
  logic signed [EW-1:0] px, py, qx, qy;

  assign en  = !out_valid || out_ready;
  assign pop = en;
  assign {dx, dy, dz} = q_data;

  // valid chain, stalls as a whole on the output
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      dv[0] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= q_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      dv[0] <= v4;
      out_valid <= dv[NW];
    end
  end

  // yaw products, yaw sums, pitch products, pitch sums
  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= dx * cos_yaw;
      p2  <= dz * sin_yaw;
      p3  <= dx * sin_yaw;
      p4  <= dz * cos_yaw;
      dy1 <= dy;
      rx2 <= round14(SX'(p1) - SX'(p2));
      zy2 <= round14(SX'(p3) + SX'(p4));
      dy2 <= dy1;
      q1  <= SW'(dy2 * cos_pitch);
      q2  <= zy2 * sin_pitch;
      q3  <= SW'(dy2 * sin_pitch);
      q4  <= zy2 * cos_pitch;
      rx3 <= rx2;
      ry4 <= round14(SX'(q1) - SX'(q2));
      dp4 <= round14(SX'(q3) + SX'(q4));
      rx4 <= rx3;
    end
  end

  // magnitudes for the divider
  assign ax4 = rx4[RW-1] ? MW'(-rx4) : MW'(rx4);
  assign ay4 = ry4[RW-1] ? MW'(-ry4) : MW'(ry4);
  assign ad4 = dp4[RW-1] ? MW'(-dp4) : MW'(dp4);

  always_ff @(posedge clk) begin
    if (en) begin
      dflg[0] <= '{neg_x: rx4[RW-1], neg_y: ry4[RW-1], neg_d: dp4[RW-1],
                   zero: dp4 == '0, nz_x: rx4 != '0, nz_y: ry4 != '0};
      dvz[0]   <= sat(EW'(dp4) + EW'(cam_z));
      dm[0]    <= ad4;
      rem_x[0] <= '0;
      rem_y[0] <= '0;
      num_x[0] <= {(MW + FOCAL_BITS)'(ax4 * focal), FRAC_BITS'(0)};
      num_y[0] <= {(MW + FOCAL_BITS)'(ay4 * focal), FRAC_BITS'(0)};
      quo_x[0] <= '0;
      quo_y[0] <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [MW:0] tx, ty, sx, sy;
    always_comb begin
      tx = {rem_x[i], num_x[i][NW-1]};
      ty = {rem_y[i], num_y[i][NW-1]};
      sx = tx - {1'b0, dm[i]};
      sy = ty - {1'b0, dm[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (en) begin
        dv[i+1] <= dv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_x[i+1] <= sx[MW] ? tx[MW-1:0] : sx[MW-1:0];
        rem_y[i+1] <= sy[MW] ? ty[MW-1:0] : sy[MW-1:0];
        quo_x[i+1] <= {quo_x[i][NW-2:0], ~sx[MW]};
        quo_y[i+1] <= {quo_y[i][NW-2:0], ~sy[MW]};
        num_x[i+1] <= num_x[i] << 1;
        num_y[i+1] <= num_y[i] << 1;
        dm[i+1]    <= dm[i];
        dflg[i+1]  <= dflg[i];
        dvz[i+1]   <= dvz[i];
      end
    end
  end

  // sign, zero-depth override, camera add and screen flip
  always_comb begin
    qx = signed'(EW'(quo_x[NW]));
    qy = signed'(EW'(quo_y[NW]));
    if (dflg[NW].zero) begin
      px = dflg[NW].nz_x ? (dflg[NW].neg_x ? SAT_LO : SAT_HI) : '0;
      py = dflg[NW].nz_y ? (dflg[NW].neg_y ? SAT_LO : SAT_HI) : '0;
    end else begin
      px = (dflg[NW].neg_x ^ dflg[NW].neg_d) ? -qx : qx;
      py = (dflg[NW].neg_y ^ dflg[NW].neg_d) ? -qy : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      screen_x   <= sat(EW'(cam_x) + px);
      screen_y   <= sat(SCREEN_Q - (EW'(cam_y) + py));
      view_z     <= signed'(dvz[NW]);
      depth_zero <= dflg[NW].zero;
    end
  end

endmodule

FILE: design/camera_vertex_transform_project.sv
// Throughput: one word per cycle while out_ready is high; the divider is fully
// pipelined, one quotient bit per stage.
// The input side keeps accepting while the output stalls until the 4-word queue fills.
// Reset: synchronous, active high; clears the pipeline and queue, camera and angles to
// zero and the focal length to 160. No clearing pass.
module camera_vertex_transform_project #(
  parameter int COORD_WIDTH  = 24,
  parameter int ANGLE_BITS   = 10,
  parameter int SCREEN_LINES = 160
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] screen_x,
  output logic signed [COORD_WIDTH-1:0] screen_y,
  output logic signed [COORD_WIDTH-1:0] view_z,
  output logic                          depth_zero,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);
  import cvt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int AB = ANGLE_BITS;
  localparam int DW = CW + 1;
  localparam int QUARTER = 1 << (AB - 2);

  // configuration registers
  logic signed [CW-1:0]         camera_x, camera_y, camera_z;
  logic [ANGLE_REG_BITS-1:0]    yaw_angle, pitch_angle;
  logic [FOCAL_BITS-1:0]        focal_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x     <= '0;
      camera_y     <= '0;
      camera_z     <= '0;
      yaw_angle    <= '0;
      pitch_angle  <= '0;
      focal_length <= FOCAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAMERA_X: camera_x     <= signed'(cfg_data);
        REG_CAMERA_Y: camera_y     <= signed'(cfg_data);
        REG_CAMERA_Z: camera_z     <= signed'(cfg_data);
        REG_YAW:      yaw_angle    <= cfg_data[ANGLE_REG_BITS-1:0];
        REG_PITCH:    pitch_angle  <= cfg_data[ANGLE_REG_BITS-1:0];
        REG_FOCAL:    focal_length <= cfg_data[FOCAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine table, built at elaboration
  logic [TRIG_FRAC:0] sine_rom [QUARTER+1];
  for (genvar p = 0; p <= QUARTER; p++) begin : g_rom
    assign sine_rom[p] = quarter_sine(p, AB - 2);
  end

  function automatic logic signed [TRIG_WIDTH-1:0] trig_lookup(input logic [AB-1:0] a);
    logic [AB-3:0]      p;
    logic [AB-2:0]      idx;
    logic [TRIG_FRAC:0] v;
    p   = a[AB-3:0];
    idx = a[AB-2] ? (AB-1)'(QUARTER) - {1'b0, p} : {1'b0, p};
    v   = sine_rom[idx];
    return a[AB-1] ? -signed'(TRIG_WIDTH'(v)) : signed'(TRIG_WIDTH'(v));
  endfunction

  logic [AB-1:0] yaw_a, pitch_a;
  logic signed [TRIG_WIDTH-1:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch;

  assign yaw_a   = AB'(yaw_angle);
  assign pitch_a = AB'(pitch_angle);

  // trig values follow the angle registers in the next cycle
  always_ff @(posedge clk) begin
    sin_yaw   <= trig_lookup(yaw_a);
    cos_yaw   <= trig_lookup(yaw_a + AB'(QUARTER));
    sin_pitch <= trig_lookup(pitch_a);
    cos_pitch <= trig_lookup(pitch_a + AB'(QUARTER));
  end

  logic            q_push, q_room, q_pop, q_valid;
  logic [3*DW-1:0] q_wdata, q_rdata;

  cvt_front #(.CW(CW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vertex_x  (vertex_x),
    .vertex_y  (vertex_y),
    .vertex_z  (vertex_z),
    .cam_x     (camera_x),
    .cam_y     (camera_y),
    .cam_z     (camera_z),
    .push      (q_push),
    .room      (q_room),
    .push_data (q_wdata)
  );

  cvt_queue #(.W(3 * DW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .room      (q_room),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  cvt_back #(.CW(CW), .SCREEN_LINES(SCREEN_LINES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .pop        (q_pop),
    .cos_yaw    (cos_yaw),
    .sin_yaw    (sin_yaw),
    .cos_pitch  (cos_pitch),
    .sin_pitch  (sin_pitch),
    .cam_x      (camera_x),
    .cam_y      (camera_y),
    .cam_z      (camera_z),
    .focal      (focal_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .view_z     (view_z),
    .depth_zero (depth_zero)
  );

  // checks
  a_focal_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_FOCAL |=>
    focal_length == $past(cfg_data[FOCAL_BITS-1:0]))
    else $error("focal length write lost");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_room)
    else $error("queue push without room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !q_valid)
    else $error("pipeline not empty after reset");

endmodule
